/* hw/rtl/mci_pkg.sv */
`timescale 1ns / 1ps
package mci_pkg;

  // element format and derived widths
  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 28;
  localparam int PROD_WIDTH = 2 * ELEM_WIDTH + 2;
  localparam int DET_WIDTH  = 2 * ELEM_WIDTH + 4;
  localparam int REM_WIDTH  = DET_WIDTH + ELEM_WIDTH + FRAC_BITS + 4;
  localparam int STEP_WIDTH = $clog2(ELEM_WIDTH + 1);
  localparam int NUM_LANES  = 3;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [DET_WIDTH-1:0]  det_t;
  typedef logic [8:0][ELEM_WIDTH-1:0]   mat_t;

  localparam elem_t ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
  localparam elem_t ELEM_ONE = (FRAC_BITS >= ELEM_WIDTH - 1) ? ELEM_MAX :
                               elem_t'(64'd1 << FRAC_BITS);
  localparam mat_t  IDENT_MAT = {ELEM_ONE, {ELEM_WIDTH{1'b0}}, {ELEM_WIDTH{1'b0}},
                                 {ELEM_WIDTH{1'b0}}, ELEM_ONE, {ELEM_WIDTH{1'b0}},
                                 {ELEM_WIDTH{1'b0}}, {ELEM_WIDTH{1'b0}}, ELEM_ONE};

  typedef enum logic [1:0] {
    KIND_IDENT   = 2'd0,
    KIND_COMPOSE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_INVERT  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DET_ISSUE,
    ST_DET_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e kind;
    elem_t in_r0c0;
    elem_t in_r0c1;
    elem_t in_r0c2;
    elem_t in_r1c0;
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r2c0;
    elem_t in_r2c1;
    elem_t in_r2c2;
  } in_t;

  typedef struct packed {
    elem_t out_r0c0;
    elem_t out_r0c1;
    elem_t out_r0c2;
    elem_t out_r1c0;
    elem_t out_r1c1;
    elem_t out_r1c2;
    elem_t out_r2c0;
    elem_t out_r2c1;
    elem_t out_r2c2;
    logic  singular;
    logic  saturated;
  } out_t;

  // cofactor operand indices: p0*p1 - q0*q1
  typedef struct packed {
    logic [3:0] p0;
    logic [3:0] p1;
    logic [3:0] q0;
    logic [3:0] q1;
  } adj_sel_t;

  function automatic adj_sel_t adj_sel(input logic [3:0] e);
    adj_sel_t s;
    case (e)
      4'd0:    s = '{p0: 4'd4, p1: 4'd8, q0: 4'd5, q1: 4'd7};
      4'd1:    s = '{p0: 4'd2, p1: 4'd7, q0: 4'd1, q1: 4'd8};
      4'd2:    s = '{p0: 4'd1, p1: 4'd5, q0: 4'd2, q1: 4'd4};
      4'd3:    s = '{p0: 4'd5, p1: 4'd6, q0: 4'd3, q1: 4'd8};
      4'd4:    s = '{p0: 4'd0, p1: 4'd8, q0: 4'd2, q1: 4'd6};
      4'd5:    s = '{p0: 4'd2, p1: 4'd3, q0: 4'd0, q1: 4'd5};
      4'd6:    s = '{p0: 4'd3, p1: 4'd7, q0: 4'd4, q1: 4'd6};
      4'd7:    s = '{p0: 4'd1, p1: 4'd6, q0: 4'd0, q1: 4'd7};
      4'd8:    s = '{p0: 4'd0, p1: 4'd4, q0: 4'd1, q1: 4'd3};
      default: s = '0;
    endcase
    return s;
  endfunction

  // row and column of a row-major element index
  function automatic logic [3:0] elem_row(input logic [3:0] e);
    logic [3:0] r;
    case (e)
      4'd0, 4'd1, 4'd2: r = 4'd0;
      4'd3, 4'd4, 4'd5: r = 4'd1;
      4'd6, 4'd7, 4'd8: r = 4'd2;
      default:          r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] elem_col(input logic [3:0] e);
    logic [3:0] c;
    case (e)
      4'd0, 4'd3, 4'd6: c = 4'd0;
      4'd1, 4'd4, 4'd7: c = 4'd1;
      4'd2, 4'd5, 4'd8: c = 4'd2;
      default:          c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic logic fits_elem(input det_t v);
    det_t hi;
    hi = v >>> (ELEM_WIDTH - 1);
    return (hi == '0) || (hi == '1);
  endfunction

  function automatic elem_t clamp_elem(input det_t v);
    elem_t r;
    if (fits_elem(v)) r = v[ELEM_WIDTH-1:0];
    else if (v[DET_WIDTH-1]) r = ELEM_MIN;
    else r = ELEM_MAX;
    return r;
  endfunction

  function automatic mat_t in_to_mat(input in_t i);
    mat_t m;
    m[0] = i.in_r0c0; m[1] = i.in_r0c1; m[2] = i.in_r0c2;
    m[3] = i.in_r1c0; m[4] = i.in_r1c1; m[5] = i.in_r1c2;
    m[6] = i.in_r2c0; m[7] = i.in_r2c1; m[8] = i.in_r2c2;
    return m;
  endfunction

  function automatic out_t mat_to_out(input mat_t m, input logic sing, input logic sat);
    out_t o;
    o.out_r0c0 = m[0]; o.out_r0c1 = m[1]; o.out_r0c2 = m[2];
    o.out_r1c0 = m[3]; o.out_r1c1 = m[4]; o.out_r1c2 = m[5];
    o.out_r2c0 = m[6]; o.out_r2c1 = m[7]; o.out_r2c2 = m[8];
    o.singular  = sing;
    o.saturated = sat;
    return o;
  endfunction

endpackage

/* hw/rtl/matrix3x3_compose_invert_top.sv */
`timescale 1ns / 1ps
// 3x3 orientation matrix unit (signed Q3.28, identity after reset). Raise start_i for
// one word while busy_o is low; the result word appears on res_o with done_o high for
// exactly one cycle and cannot be held off, so capture it then. One request at a time:
// identity and read finish without the lanes, compose uses three multiplier lanes that
// work one result element a cycle, and inverse, when the determinant is non-zero, also
// runs the three bit-serial divider lanes, which need ELEM_WIDTH+1 steps for each group
// of three elements.
module matrix3x3_compose_invert_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mci_pkg::in_t  in_i,
  output logic          busy_o,
  output logic          done_o,
  output mci_pkg::out_t res_o
);
  import mci_pkg::*;

  state_e      st_q, st_d;
  kind_e       kind_q;
  logic [3:0]  e_q, iss_idx_q;
  logic [1:0]  g_q;
  logic        iss_v_q, issue, merge_sub, div_start;
  logic        sat_q, sing_q, done_q, accept;
  mat_t        m_q, r_q, res_q;
  det_t        det_q, sum;
  out_t        out_q;
  adj_sel_t    asel;
  logic [3:0]  row, col;

  elem_t       mul_a [NUM_LANES];
  elem_t       mul_b [NUM_LANES];
  prod_t       mul_p [NUM_LANES];
  elem_t       div_a [NUM_LANES];
  elem_t       div_q [NUM_LANES];
  logic [NUM_LANES-1:0] div_done, div_sat;

  assign accept = start_i && !busy_o;
  assign busy_o = (st_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = out_q;

  // lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    mci_mul_lane u_mul (
      .clk_i (clk_i),
      .a_i   (mul_a[l]),
      .b_i   (mul_b[l]),
      .p_o   (mul_p[l])
    );
    assign div_a[l] = elem_t'(res_q[4'(g_q * 3 + l)]);
    mci_div_lane u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .a_i     (div_a[l]),
      .det_i   (det_q),
      .done_o  (div_done[l]),
      .q_o     (div_q[l]),
      .sat_o   (div_sat[l])
    );
  end

  // merge: sum of lane products, second one subtracted for cofactors
  always_comb begin
    sum = det_t'(mul_p[0]) + (merge_sub ? -det_t'(mul_p[1]) : det_t'(mul_p[1]))
        + det_t'(mul_p[2]);
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.kind == KIND_COMPOSE || in_i.kind == KIND_INVERT) st_d = ST_MUL;
          else st_d = ST_DONE;
        end
      end
      ST_MUL: begin
        if (e_q == 4'd9) st_d = (kind_q == KIND_INVERT) ? ST_DET_ISSUE : ST_DONE;
      end
      ST_DET_ISSUE: st_d = ST_DET_SUM;
      ST_DET_SUM:   st_d = ST_DIV_START;
      ST_DIV_START: st_d = (det_q == '0) ? ST_DONE : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done[0]) st_d = (g_q == 2'd2) ? ST_DONE : ST_DIV_START;
      end
      ST_DONE:      st_d = ST_IDLE;
      default:      st_d = ST_IDLE;
    endcase
  end

  // lane operands and strobes
  always_comb begin
    issue     = 1'b0;
    div_start = 1'b0;
    merge_sub = (st_q == ST_MUL) && (kind_q == KIND_INVERT);
    asel      = adj_sel(e_q);
    row       = elem_row(e_q);
    col       = elem_col(e_q);
    for (int l = 0; l < NUM_LANES; l++) begin
      mul_a[l] = '0;
      mul_b[l] = '0;
    end
    case (st_q)
      ST_MUL: begin
        if (e_q != 4'd9) begin
          issue = 1'b1;
          if (kind_q == KIND_INVERT) begin
            mul_a[0] = m_q[asel.p0];
            mul_b[0] = m_q[asel.p1];
            mul_a[1] = m_q[asel.q0];
            mul_b[1] = m_q[asel.q1];
          end else begin
            for (int l = 0; l < NUM_LANES; l++) begin
              mul_a[l] = r_q[4'(row * 3 + l)];
              mul_b[l] = m_q[4'(l * 3) + col];
            end
          end
        end
      end
      ST_DET_ISSUE: begin
        for (int l = 0; l < NUM_LANES; l++) begin
          mul_a[l] = res_q[4'(l)];
          mul_b[l] = m_q[4'(l * 3)];
        end
      end
      ST_DIV_START: div_start = (det_q != '0);
      default: ;
    endcase
  end

  // control state and the kept matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      kind_q  <= KIND_IDENT;
      e_q     <= '0;
      g_q     <= '0;
      iss_v_q <= 1'b0;
      sat_q   <= 1'b0;
      sing_q  <= 1'b0;
      done_q  <= 1'b0;
      m_q     <= IDENT_MAT;
    end else begin
      st_q    <= st_d;
      iss_v_q <= issue;
      done_q  <= (st_q == ST_DONE);
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q <= in_i.kind;
            e_q    <= '0;
            g_q    <= '0;
            sat_q  <= 1'b0;
            sing_q <= 1'b0;
            if (in_i.kind == KIND_IDENT) m_q <= IDENT_MAT;
          end
        end
        ST_MUL: begin
          if (issue) e_q <= e_q + 1'b1;
          if (iss_v_q && !fits_elem(sum)) sat_q <= 1'b1;
        end
        ST_DIV_START: begin
          if (det_q == '0) begin
            sing_q <= 1'b1;
            sat_q  <= 1'b0;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done[0]) begin
            g_q <= g_q + 1'b1;
            if (|div_sat) sat_q <= 1'b1;
          end
        end
        ST_DONE: begin
          if (kind_q == KIND_COMPOSE) m_q <= res_q;
        end
        default: ;
      endcase
    end
  end

  // result words
  always_ff @(posedge clk_i) begin
    iss_idx_q <= e_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          r_q   <= in_to_mat(in_i);
          res_q <= (in_i.kind == KIND_IDENT) ? IDENT_MAT : m_q;
        end
      end
      ST_MUL: begin
        if (iss_v_q) res_q[iss_idx_q] <= clamp_elem(sum);
      end
      ST_DET_SUM: det_q <= sum;
      ST_DIV_START: begin
        if (det_q == '0) res_q <= '0;
      end
      ST_DIV_WAIT: begin
        if (div_done[0]) begin
          for (int l = 0; l < NUM_LANES; l++) res_q[4'(g_q * 3 + l)] <= div_q[l];
        end
      end
      ST_DONE: out_q <= mat_to_out(res_q, sing_q, sat_q);
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");
  a_sing_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.singular |-> !res_o.saturated && res_o.out_r0c0 == '0
      && res_o.out_r1c1 == '0 && res_o.out_r2c2 == '0)
    else $error("singular result not cleared");
  a_ident_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.kind == KIND_IDENT |-> ##2 done_o && res_o.out_r0c1 == '0)
    else $error("identity result late or wrong");
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done[0] |-> div_done[1] && div_done[2] && st_q == ST_DIV_WAIT)
    else $error("divider lanes out of step");
`endif

endmodule

/* hw/rtl/mci_mul_lane.sv */
`timescale 1ns / 1ps
module mci_mul_lane (
  input  logic           clk_i,
  input  mci_pkg::elem_t a_i,
  input  mci_pkg::elem_t b_i,
  output mci_pkg::prod_t p_o
);
  import mci_pkg::*;

  logic [ELEM_WIDTH-1:0]   a_mag, b_mag;
  logic [2*ELEM_WIDTH-1:0] mag;
  logic [PROD_WIDTH-1:0]   rnd;
  prod_t                   p_d, p_q;

  // sign-magnitude product, rounded half away from zero
  always_comb begin
    a_mag = a_i[ELEM_WIDTH-1] ? (~a_i + 1'b1) : a_i;
    b_mag = b_i[ELEM_WIDTH-1] ? (~b_i + 1'b1) : b_i;
    mag   = a_mag * b_mag;
    rnd   = (PROD_WIDTH'(mag) + (PROD_WIDTH'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    p_d   = (a_i[ELEM_WIDTH-1] ^ b_i[ELEM_WIDTH-1]) ? -prod_t'(rnd) : prod_t'(rnd);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/mci_div_lane.sv */
`timescale 1ns / 1ps
module mci_div_lane (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mci_pkg::elem_t a_i,
  input  mci_pkg::det_t  det_i,
  output logic           done_o,
  output mci_pkg::elem_t q_o,
  output logic           sat_o
);
  import mci_pkg::*;

  logic                  busy_q, done_q, neg_q, ge;
  logic [STEP_WIDTH-1:0] cnt_q;
  logic [REM_WIDTH-1:0]  rem_q, d_q, n_start, d_start;
  logic [ELEM_WIDTH:0]   q_q;
  logic [ELEM_WIDTH-1:0] a_mag, q_mag;
  logic [DET_WIDTH-1:0]  d_mag;

  // numerator 2*|a|*2^F + |det|, divisor 2*|det| aligned to quotient bit W
  always_comb begin
    a_mag   = a_i[ELEM_WIDTH-1] ? (~a_i + 1'b1) : a_i;
    d_mag   = det_i[DET_WIDTH-1] ? (~det_i + 1'b1) : det_i;
    n_start = (REM_WIDTH'(a_mag) << (FRAC_BITS + 1)) + REM_WIDTH'(d_mag);
    d_start = REM_WIDTH'(d_mag) << (ELEM_WIDTH + 1);
    ge      = rem_q >= d_q;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_WIDTH'(ELEM_WIDTH);
      end else if (busy_q) begin
        if (cnt_q == '0) busy_q <= 1'b0;
        else cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= n_start;
      d_q   <= d_start;
      q_q   <= '0;
      neg_q <= a_i[ELEM_WIDTH-1] ^ det_i[DET_WIDTH-1];
    end else if (busy_q) begin
      if (ge) rem_q <= rem_q - d_q;
      q_q <= {q_q[ELEM_WIDTH-1:0], ge};
      d_q <= d_q >> 1;
    end
  end

  // sign and clamp; top quotient bit set means out of range
  always_comb begin
    q_mag = q_q[ELEM_WIDTH-1:0];
    if (!neg_q) begin
      sat_o = q_q[ELEM_WIDTH] | q_mag[ELEM_WIDTH-1];
      q_o   = sat_o ? ELEM_MAX : elem_t'(q_mag);
    end else begin
      sat_o = q_q[ELEM_WIDTH] | (q_mag > ELEM_MIN);
      q_o   = sat_o ? ELEM_MIN : elem_t'(~q_mag + 1'b1);
    end
  end

  assign done_o = done_q;

endmodule
